[rtl/adc_key_ladder_mode_speed_top_assert.svh]
// Assertion macros shared by the key ladder decoder RTL
`ifndef ADC_KEY_LADDER_MODE_SPEED_TOP_ASSERT_SVH
`define ADC_KEY_LADDER_MODE_SPEED_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define AKL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define AKL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKL_ASSERT(lbl, prop, msg)
`define AKL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/akl_pkg.sv]
// Shared types and constants of the key ladder decoder
package akl_pkg;

  localparam int CODE_W     = 12;
  localparam int TICK_W     = 32;
  localparam int SPD_W      = 13;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int unsigned SPEED_STEP_DEF = 500;
  localparam int unsigned SPEED_MAX_DEF  = 8000;

  // drive modes
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVOID = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_LO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_LO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_HI     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_HI   = 3'd6;

  // register reset values
  localparam logic [TICK_W-1:0] RST_DEBOUNCE = 32'd200;
  localparam logic [CODE_W-1:0] RST_MODE_LO  = 12'd6;
  localparam logic [CODE_W-1:0] RST_MODE_HI  = 12'd170;
  localparam logic [CODE_W-1:0] RST_UP_LO    = 12'd342;
  localparam logic [CODE_W-1:0] RST_UP_HI    = 12'd568;
  localparam logic [CODE_W-1:0] RST_DOWN_LO  = 12'd569;
  localparam logic [CODE_W-1:0] RST_DOWN_HI  = 12'd853;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_MODE_ADV    = 3'd1,
    ACT_MODE_BOUNCE = 3'd2,
    ACT_SPEED_UP    = 3'd3,
    ACT_SPEED_DOWN  = 3'd4,
    ACT_READ_FAIL   = 3'd5
  } action_t;

  typedef struct packed {
    logic [TICK_W-1:0] debounce;
    logic [CODE_W-1:0] mode_lo;
    logic [CODE_W-1:0] mode_hi;
    logic [CODE_W-1:0] up_lo;
    logic [CODE_W-1:0] up_hi;
    logic [CODE_W-1:0] down_lo;
    logic [CODE_W-1:0] down_hi;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              failed;
    logic [TICK_W-1:0] tick;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SPD_W-1:0]  speed;
    action_t           action;
    logic [CODE_W-1:0] peak;
  } result_t;

endpackage

[rtl/akl_cfg_regs.sv]
// Configuration register file of the key ladder decoder
module akl_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [akl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [akl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output akl_pkg::cfg_t                    cfg
);

  akl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= akl_pkg::RST_DEBOUNCE;
      cfg_r.mode_lo  <= akl_pkg::RST_MODE_LO;
      cfg_r.mode_hi  <= akl_pkg::RST_MODE_HI;
      cfg_r.up_lo    <= akl_pkg::RST_UP_LO;
      cfg_r.up_hi    <= akl_pkg::RST_UP_HI;
      cfg_r.down_lo  <= akl_pkg::RST_DOWN_LO;
      cfg_r.down_hi  <= akl_pkg::RST_DOWN_HI;
    end else if (cfg_we) begin
      case (cfg_index)
        akl_pkg::CFG_DEBOUNCE: cfg_r.debounce <= cfg_data[akl_pkg::TICK_W-1:0];
        akl_pkg::CFG_MODE_LO:  cfg_r.mode_lo  <= cfg_data[akl_pkg::CODE_W-1:0];
        akl_pkg::CFG_MODE_HI:  cfg_r.mode_hi  <= cfg_data[akl_pkg::CODE_W-1:0];
        akl_pkg::CFG_UP_LO:    cfg_r.up_lo    <= cfg_data[akl_pkg::CODE_W-1:0];
        akl_pkg::CFG_UP_HI:    cfg_r.up_hi    <= cfg_data[akl_pkg::CODE_W-1:0];
        akl_pkg::CFG_DOWN_LO:  cfg_r.down_lo  <= cfg_data[akl_pkg::CODE_W-1:0];
        akl_pkg::CFG_DOWN_HI:  cfg_r.down_hi  <= cfg_data[akl_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/akl_core.sv]
// Peak tracker, band decode and mode/speed state of the key ladder decoder
`include "adc_key_ladder_mode_speed_top_assert.svh"
module akl_core #(
  parameter int unsigned SPEED_STEP = akl_pkg::SPEED_STEP_DEF,
  parameter int unsigned SPEED_MAX  = akl_pkg::SPEED_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  akl_pkg::cfg_t     cfg,
  input  logic              step,      // item in the input stage is consumed
  input  akl_pkg::item_t    item,
  output logic              burst_end, // item yields a result word
  output akl_pkg::result_t  res
);

  localparam int SpdW = akl_pkg::SPD_W;
  localparam logic [SpdW:0]   StepExt = (SpdW+1)'(SPEED_STEP);
  localparam logic [SpdW:0]   MaxExt  = (SpdW+1)'(SPEED_MAX);
  localparam logic [SpdW-1:0] StepC   = SpdW'(SPEED_STEP);
  localparam logic [SpdW-1:0] MaxC    = SpdW'(SPEED_MAX);

  logic [akl_pkg::CODE_W-1:0] peak_r, peak_nxt, peak_upd, peak_res;
  logic [akl_pkg::MODE_W-1:0] mode_r, mode_nxt, mode_adv;
  logic [SpdW-1:0]            speed_r, speed_nxt, spd_up, spd_dn;
  logic [akl_pkg::TICK_W-1:0] last_tick_r, last_tick_nxt, interval;
  logic [SpdW:0]              spd_sum;
  logic                       in_mode, in_up, in_down, bounced;
  akl_pkg::action_t           action;

  always_comb begin
    peak_upd = (item.code > peak_r) ? item.code : peak_r;
    peak_res = item.failed ? peak_r : peak_upd;
    in_mode  = (peak_res >= cfg.mode_lo) && (peak_res <= cfg.mode_hi);
    in_up    = (peak_res >= cfg.up_lo)   && (peak_res <= cfg.up_hi);
    in_down  = (peak_res >= cfg.down_lo) && (peak_res <= cfg.down_hi);
    interval = item.tick - last_tick_r;   // wraps
    bounced  = interval < cfg.debounce;

    case (mode_r)
      akl_pkg::MODE_STOP:  mode_adv = akl_pkg::MODE_TRACE;
      akl_pkg::MODE_TRACE: mode_adv = akl_pkg::MODE_AVOID;
      akl_pkg::MODE_AVOID: mode_adv = akl_pkg::MODE_STOP;
      default:             mode_adv = mode_r;
    endcase

    spd_sum = {1'b0, speed_r} + StepExt;
    spd_up  = (spd_sum > MaxExt) ? MaxC : spd_sum[SpdW-1:0];
    spd_dn  = (speed_r >= StepC) ? (speed_r - StepC) : '0;

    peak_nxt      = '0;
    mode_nxt      = mode_r;
    speed_nxt     = speed_r;
    last_tick_nxt = last_tick_r;
    action        = akl_pkg::ACT_NONE;
    burst_end     = item.failed || item.last;

    if (item.failed) begin
      action = akl_pkg::ACT_READ_FAIL;
    end else if (!item.last) begin
      peak_nxt = peak_upd;
    end else if (in_mode) begin
      if (bounced) begin
        action = akl_pkg::ACT_MODE_BOUNCE;
      end else begin
        action        = akl_pkg::ACT_MODE_ADV;
        mode_nxt      = mode_adv;
        last_tick_nxt = item.tick;
      end
    end else if (in_up) begin
      action    = akl_pkg::ACT_SPEED_UP;
      speed_nxt = spd_up;
    end else if (in_down) begin
      action    = akl_pkg::ACT_SPEED_DOWN;
      speed_nxt = spd_dn;
    end

    res.mode   = mode_nxt;
    res.speed  = speed_nxt;
    res.action = action;
    res.peak   = peak_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      mode_r      <= akl_pkg::MODE_STOP;
      speed_r     <= '0;
      last_tick_r <= '0;
    end else if (step) begin
      peak_r      <= peak_nxt;
      mode_r      <= mode_nxt;
      speed_r     <= speed_nxt;
      last_tick_r <= last_tick_nxt;
    end
  end

  `AKL_ASSERT(a_mode_valid, mode_r != akl_pkg::MODE_BAD, "drive mode reached invalid code")
  `AKL_ASSERT(a_speed_cap, speed_r <= MaxC, "speed above maximum")
  `AKL_ASSERT(a_peak_clear, step && burst_end |=> peak_r == '0, "peak not cleared at burst end")

endmodule

[rtl/adc_key_ladder_mode_speed_top.sv]
// Top level of the resistor-ladder key decoder with drive mode and speed control
//
// Input channel (in_*): one word per ADC sample, valid/ready. A burst of samples
// ends with in_sample_last or with in_read_failed; the block keeps the burst peak.
// Output channel (out_*): one word per burst end, carrying mode, speed, action
// and peak. Mid-burst samples give no word.
// Config port (cfg_*): single-cycle write, index 0 debounce ticks, 1..6 band
// bounds (mode, up, down; low then high). Write only while idle.
//
// Pipeline: input register -> decode/state update -> output register.
// A burst-end word moves from the input register to the output register when
// the output slot is free. Throughput: one word per cycle while nothing stalls;
// the state update loops through the peak, mode, speed and last-press registers.
// Stall: if the output register holds an untaken word, a burst-end word waits
// in the input register and in_ready drops; mid-burst words still flow since
// they need no output slot. in_ready is combinational from out_ready.
// Reset (rst_n low, synchronous): both stages empty, peak 0, mode stop,
// speed 0, last press tick 0, config back to defaults.
`include "adc_key_ladder_mode_speed_top_assert.svh"
module adc_key_ladder_mode_speed_top #(
  parameter int unsigned SPEED_STEP = akl_pkg::SPEED_STEP_DEF,
  parameter int unsigned SPEED_MAX  = akl_pkg::SPEED_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_we,
  input  logic [akl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [akl_pkg::CFG_DATA_W-1:0]  cfg_data,
  // samples
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [akl_pkg::CODE_W-1:0]      in_sample_code,
  input  logic                            in_sample_last,
  input  logic                            in_read_failed,
  input  logic [akl_pkg::TICK_W-1:0]      in_tick_now,
  // results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [akl_pkg::MODE_W-1:0]      out_drive_mode,
  output logic [akl_pkg::SPD_W-1:0]       out_speed_value,
  output logic [2:0]                      out_press_action,
  output logic [akl_pkg::CODE_W-1:0]      out_peak_code
);

  akl_pkg::cfg_t    cfg;
  akl_pkg::item_t   s1_item_r;
  akl_pkg::result_t res, out_res_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             s1_adv, s1_ends, in_take;

  akl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  akl_core #(
    .SPEED_STEP (SPEED_STEP),
    .SPEED_MAX  (SPEED_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (s1_adv),
    .item      (s1_item_r),
    .burst_end (s1_ends),
    .res       (res)
  );

  // a burst-end word needs a free (or draining) output slot
  assign s1_adv   = s1_valid_r && (!s1_ends || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_ends) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.code   <= in_sample_code;
      s1_item_r.last   <= in_sample_last;
      s1_item_r.failed <= in_read_failed;
      s1_item_r.tick   <= in_tick_now;
    end
    if (s1_adv && s1_ends) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_mode   = out_res_r.mode;
  assign out_speed_value  = out_res_r.speed;
  assign out_press_action = out_res_r.action;
  assign out_peak_code    = out_res_r.peak;

  `AKL_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "stages not empty after reset")
  `AKL_ASSERT(a_result_loaded, s1_adv && s1_ends |=> out_valid_r, "burst end lost its result word")
  `AKL_ASSERT(a_stall_cause, !in_ready |-> s1_valid_r && s1_ends && out_valid_r && !out_ready, "input stalled without a full output")
  `AKL_ASSERT(a_out_drain, out_valid_r && out_ready && !(s1_adv && s1_ends) |=> !out_valid_r, "taken word not cleared")

endmodule

[test/adc_key_ladder_checker.sv]
`timescale 1ns / 100ps
// Checker for the key ladder decoder: tracks mode, speed and burst peak, compares press reports
module adc_key_ladder_checker
  import akl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CODE_W-1:0]     in_sample_code,
  input  logic                  in_sample_last,
  input  logic                  in_read_failed,
  input  logic [TICK_W-1:0]     in_tick_now,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [MODE_W-1:0]     out_drive_mode,
  input  logic [SPD_W-1:0]      out_speed_value,
  input  logic [2:0]            out_press_action,
  input  logic [CODE_W-1:0]     out_peak_code,
  output int                    fail_count,
  output int                    results_pending
);

  cfg_t              regs;
  logic [CODE_W-1:0] peak_acc;
  logic [MODE_W-1:0] mode_now;
  logic [SPD_W-1:0]  speed_now;
  logic [TICK_W-1:0] last_accept_tick;
  result_t           press_reports_q[$];

  initial begin
    fail_count = 0;
    results_pending = 0;
  end

  // one word into the decoder; returns 1 when it ends a burst
  function automatic bit predict_press(input logic [CODE_W-1:0] code, input logic last,
                                       input logic failed, input logic [TICK_W-1:0] tick,
                                       output result_t rpt);
    logic [TICK_W-1:0] since;
    rpt = '0;
    rpt.action = ACT_NONE;
    if (failed) begin
      // failed sample's own code is dropped
      rpt.peak = peak_acc;
      rpt.action = ACT_READ_FAIL;
    end else begin
      if (code > peak_acc) peak_acc = code;
      if (!last) return 1'b0;
      rpt.peak = peak_acc;
      since = tick - last_accept_tick;
      if (peak_acc >= regs.mode_lo && peak_acc <= regs.mode_hi) begin
        if (since < regs.debounce) begin
          rpt.action = ACT_MODE_BOUNCE;
        end else begin
          last_accept_tick = tick;
          case (mode_now)
            MODE_STOP:  mode_now = MODE_TRACE;
            MODE_TRACE: mode_now = MODE_AVOID;
            MODE_AVOID: mode_now = MODE_STOP;
            default: ;
          endcase
          rpt.action = ACT_MODE_ADV;
        end
      end else if (peak_acc >= regs.up_lo && peak_acc <= regs.up_hi) begin
        if (speed_now <= SPD_W'(SPEED_MAX_DEF - SPEED_STEP_DEF))
          speed_now = speed_now + SPD_W'(SPEED_STEP_DEF);
        else
          speed_now = SPD_W'(SPEED_MAX_DEF);
        rpt.action = ACT_SPEED_UP;
      end else if (peak_acc >= regs.down_lo && peak_acc <= regs.down_hi) begin
        if (speed_now >= SPD_W'(SPEED_STEP_DEF))
          speed_now = speed_now - SPD_W'(SPEED_STEP_DEF);
        else
          speed_now = '0;
        rpt.action = ACT_SPEED_DOWN;
      end
    end
    peak_acc = '0;
    rpt.mode = mode_now;
    rpt.speed = speed_now;
    return 1'b1;
  endfunction

  function automatic void flag_field(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t rpt;
    result_t want;
    if (!rst_n) begin
      regs = '{debounce: RST_DEBOUNCE, mode_lo: RST_MODE_LO, mode_hi: RST_MODE_HI,
               up_lo: RST_UP_LO, up_hi: RST_UP_HI, down_lo: RST_DOWN_LO,
               down_hi: RST_DOWN_HI};
      peak_acc = '0;
      mode_now = MODE_STOP;
      speed_now = '0;
      last_accept_tick = '0;
      press_reports_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: regs.debounce = cfg_data;
          CFG_MODE_LO:  regs.mode_lo  = cfg_data[CODE_W-1:0];
          CFG_MODE_HI:  regs.mode_hi  = cfg_data[CODE_W-1:0];
          CFG_UP_LO:    regs.up_lo    = cfg_data[CODE_W-1:0];
          CFG_UP_HI:    regs.up_hi    = cfg_data[CODE_W-1:0];
          CFG_DOWN_LO:  regs.down_lo  = cfg_data[CODE_W-1:0];
          CFG_DOWN_HI:  regs.down_hi  = cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      // a report can never belong to a word taken at the same edge
      if (out_valid && out_ready) begin
        if (press_reports_q.size() == 0) begin
          $display("%0t: report with none expected, got mode %0d speed %0d action %0d peak %0d",
                   $time, out_drive_mode, out_speed_value, out_press_action, out_peak_code);
          fail_count++;
        end else begin
          want = press_reports_q.pop_front();
          flag_field("drive_mode", want.mode, out_drive_mode);
          flag_field("speed_value", want.speed, out_speed_value);
          flag_field("press_action", want.action, out_press_action);
          flag_field("peak_code", want.peak, out_peak_code);
        end
      end
      if (in_valid && in_ready) begin
        if (predict_press(in_sample_code, in_sample_last, in_read_failed, in_tick_now, rpt))
          press_reports_q.push_back(rpt);
      end
    end
    results_pending <= press_reports_q.size();
  end

endmodule

[test/tb_adc_key_ladder_mode_speed_top.sv]
`timescale 1ns / 100ps
// Testbench top for the key ladder decoder: stimulus, traffic shaping and verdict
module tb_adc_key_ladder_mode_speed_top;
  import akl_pkg::*;

  // generous bound for the slowest legal run
  localparam int CYCLE_LIMIT  = 400000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES  = 120;
  // margin for the pipeline registers to empty before touching config
  localparam int DRAIN_CYCLES = 4;

  // receiver behaviors
  localparam int RX_ALWAYS  = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_SPARSE  = 2;
  localparam int RX_PATTERN = 3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CODE_W-1:0]     in_sample_code;
  logic                  in_sample_last;
  logic                  in_read_failed;
  logic [TICK_W-1:0]     in_tick_now;
  logic                  out_valid;
  logic                  out_ready;
  logic [MODE_W-1:0]     out_drive_mode;
  logic [SPD_W-1:0]      out_speed_value;
  logic [2:0]            out_press_action;
  logic [CODE_W-1:0]     out_peak_code;
  int                    fail_count;
  int                    results_pending;

  // band settings as last written, used only to aim peaks at bands
  cfg_t              band_regs;
  logic [TICK_W-1:0] tick_now;
  int                burst_left;
  int                tx_gap_max;
  int                rx_style;
  logic [7:0]        rx_pattern;
  int                hold_requests;

  adc_key_ladder_mode_speed_top i_dut (.*);

  adc_key_ladder_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one word and hold it until the block takes it. Returns at the
  // accepting edge with nothing scheduled, so the caller may drive again.
  task automatic send_word(input logic [CODE_W-1:0] code, input logic last,
                           input logic failed, input logic [TICK_W-1:0] tick);
    in_valid       <= 1'b1;
    in_sample_code <= code;
    in_sample_last <= last;
    in_read_failed <= failed;
    in_tick_now    <= tick;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender in bursts: a random gap opens each burst of back-to-back words.
  // The tick mostly creeps (debounce decisions near the limit), sometimes
  // jumps, sometimes lands anywhere so every tick bit toggles.
  task automatic offer_word(input logic [CODE_W-1:0] code, input logic last,
                            input logic failed);
    int gap;
    int r;
    if (burst_left == 0) begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    r = $urandom_range(0, 99);
    if (r < 60)
      tick_now = tick_now + TICK_W'($urandom_range(0, 120));
    else if (r < 85)
      tick_now = tick_now + TICK_W'($urandom_range(150, 400));
    else if (r < 95)
      tick_now = tick_now + TICK_W'($urandom_range(0, 100000));
    else
      tick_now = TICK_W'($urandom);
    send_word(code, last, failed, tick_now);
  endtask

  // Stop offering and wait for every outstanding report, then let the
  // pipeline settle in case a mid-burst word is still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write per edge; cfg_we stays high across the sequence.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Band registers get random junk above bit 11; the block must drop it.
  task automatic program_regs(input cfg_t r);
    write_reg(CFG_DEBOUNCE, r.debounce);
    write_reg(CFG_MODE_LO, {20'($urandom), r.mode_lo});
    write_reg(CFG_MODE_HI, {20'($urandom), r.mode_hi});
    write_reg(CFG_UP_LO, {20'($urandom), r.up_lo});
    write_reg(CFG_UP_HI, {20'($urandom), r.up_hi});
    write_reg(CFG_DOWN_LO, {20'($urandom), r.down_lo});
    write_reg(CFG_DOWN_HI, {20'($urandom), r.down_hi});
    cfg_we <= 1'b0;
    band_regs = r;
  endtask

  task automatic set_traffic(input int rx, input int gap);
    rx_style   <= rx;
    rx_pattern <= 8'($urandom) | 8'h01;   // never an all-stall pattern
    tx_gap_max = gap;
  endtask

  function automatic logic [CODE_W-1:0] band_code(input logic [CODE_W-1:0] lo,
                                                  input logic [CODE_W-1:0] hi);
    if (lo > hi) return CODE_W'($urandom);
    return CODE_W'($urandom_range(hi, lo));
  endfunction

  // Peak of the next burst: inside a band, anywhere, on a bound +/-1, or a rail.
  function automatic logic [CODE_W-1:0] pick_peak(input int up_pct);
    logic [CODE_W-1:0] bnd [6];
    logic [CODE_W-1:0] pk;
    int r;
    bnd = '{band_regs.mode_lo, band_regs.mode_hi, band_regs.up_lo, band_regs.up_hi,
            band_regs.down_lo, band_regs.down_hi};
    r = $urandom_range(0, 99);
    if (r < 25) return band_code(band_regs.mode_lo, band_regs.mode_hi);
    if (r < 70) begin
      if ($urandom_range(0, 99) < up_pct) return band_code(band_regs.up_lo, band_regs.up_hi);
      return band_code(band_regs.down_lo, band_regs.down_hi);
    end
    if (r < 82) return CODE_W'($urandom);
    if (r < 93) begin
      pk = bnd[$urandom_range(0, 5)] + CODE_W'($urandom_range(0, 2));
      return pk - 1'b1;
    end
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // Random band layout; bands may wrap or come out empty on purpose.
  function automatic cfg_t rand_regs();
    cfg_t r;
    logic [CODE_W-1:0] bnd [6];
    logic [CODE_W-1:0] a;
    r.debounce = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom) : TICK_W'($urandom_range(0, 600));
    for (int k = 0; k < 6; k += 2) begin
      a = CODE_W'($urandom);
      bnd[k]   = a;
      bnd[k+1] = a + CODE_W'($urandom_range(0, 600));
      if ($urandom_range(0, 5) == 0) begin
        bnd[k]   = bnd[k+1];
        bnd[k+1] = a - 1'b1;
      end
    end
    r.mode_lo = bnd[0];
    r.mode_hi = bnd[1];
    r.up_lo   = bnd[2];
    r.up_hi   = bnd[3];
    r.down_lo = bnd[4];
    r.down_hi = bnd[5];
    return r;
  endfunction

  // Mostly well-formed bursts with one planted peak; some bursts die on a
  // failed read; a few lone words with random flags as noise. One third in,
  // the receiver is told to hold off while words keep coming; two thirds in,
  // the sender stops until every report is back.
  task automatic run_random(input int n_words, input int up_pct);
    int sent;
    int len;
    int top_pos;
    int fail_pos;
    bit held;
    bit paused;
    logic [CODE_W-1:0] pk;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < n_words) begin
      if (!held && sent >= n_words / 3) begin
        held = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      if (!paused && sent >= 2 * n_words / 3) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 99) < 8) begin
        offer_word(CODE_W'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        pk = pick_peak(up_pct);
        top_pos = $urandom_range(0, len - 1);
        fail_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++) begin
          if (i == fail_pos) begin
            offer_word(CODE_W'($urandom), 1'($urandom), 1'b1);
            sent++;
            break;
          end
          offer_word((i == top_pos) ? pk : CODE_W'($urandom_range(0, pk)), i == len - 1, 1'b0);
          sent++;
        end
      end
    end
  endtask

  // Receiver: own process, own stall pattern; a hold-off request parks it
  // for HOLD_CYCLES counted here.
  initial begin : receiver
    int hold_left;
    int holds_served;
    int pat_pos;
    hold_left = 0;
    holds_served = 0;
    pat_pos = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ready <= rx_pattern[pat_pos];
            pat_pos = (pat_pos + 1) % 8;
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    cfg_t dflt;
    dflt = '{debounce: RST_DEBOUNCE, mode_lo: RST_MODE_LO, mode_hi: RST_MODE_HI,
             up_lo: RST_UP_LO, up_hi: RST_UP_HI, down_lo: RST_DOWN_LO, down_hi: RST_DOWN_HI};
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_DEBOUNCE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_sample_code <= '0;
    in_sample_last <= 1'b0;
    in_read_failed <= 1'b0;
    in_tick_now    <= '0;
    rx_style       <= RX_ALWAYS;
    rx_pattern     <= 8'hFF;
    hold_requests  <= 0;
    band_regs  = dflt;
    tick_now   = '0;
    burst_left = 0;
    tx_gap_max = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset bands (mode 6..170, up 342..568, down 569..853) ----
    send_word(12'd0, 1'b1, 1'b0, 32'd10);          // peak zero, in no band
    send_word(12'hFFF, 1'b1, 1'b0, 32'd20);        // full-scale code, in no band
    send_word(12'd100, 1'b0, 1'b0, 32'd900);       // burst continues, no report
    send_word(12'd6, 1'b1, 1'b0, 32'd1000);        // peak 100: stop -> trace
    send_word(12'd170, 1'b1, 1'b0, 32'd1100);      // only 100 ticks later: debounced
    send_word(12'd6, 1'b1, 1'b0, 32'd1200);        // exactly the debounce time: avoid
    send_word(12'd50, 1'b1, 1'b0, 32'd1400);       // avoid wraps back to stop
    send_word(12'd342, 1'b1, 1'b0, 32'd1450);      // up band low edge
    send_word(12'd568, 1'b1, 1'b0, 32'd1460);      // up band high edge
    send_word(12'd569, 1'b1, 1'b0, 32'd1470);      // down band low edge
    send_word(12'd853, 1'b1, 1'b0, 32'd1480);      // down band high edge, back to 0
    send_word(12'd700, 1'b1, 1'b0, 32'd1490);      // speed already 0: stays 0
    send_word(12'd171, 1'b1, 1'b0, 32'd1500);      // gaps between and past the bands
    send_word(12'd341, 1'b1, 1'b0, 32'd1510);
    send_word(12'd854, 1'b1, 1'b0, 32'd1520);
    send_word(12'd5, 1'b1, 1'b0, 32'd1530);
    send_word(12'd400, 1'b0, 1'b0, 32'd1540);      // failed read ends the burst,
    send_word(12'hFFF, 1'b1, 1'b1, 32'd1550);      // its own code ignored, last too
    send_word(12'd3, 1'b0, 1'b1, 32'd1560);        // failure as first word: peak 0
    send_word(12'd10, 1'b1, 1'b0, 32'hFFFF_FFFF);  // tick near wrap: accepted
    send_word(12'd10, 1'b1, 1'b0, 32'd80);         // wrapped, 81 ticks: debounced
    send_word(12'd10, 1'b1, 1'b0, 32'd199);        // wrapped, 200 ticks: accepted
    drain();

    // ---- random on reset bands ----
    set_traffic(RX_COIN, 6);
    run_random(130, 50);
    drain();

    // debounce off, overlapping mode/up bands, single-code down band at the top rail;
    // speed pushed up into saturation
    program_regs('{debounce: '0, mode_lo: 12'd0, mode_hi: 12'd100, up_lo: 12'd50,
                   up_hi: 12'd600, down_lo: 12'hFFF, down_hi: 12'hFFF});
    set_traffic(RX_PATTERN, 0);
    run_random(140, 95);
    drain();

    // debounce at maximum, empty mode band, down band over everything;
    // speed driven down to zero
    program_regs('{debounce: '1, mode_lo: 12'd200, mode_hi: 12'd100, up_lo: 12'd300,
                   up_hi: 12'd300, down_lo: 12'd0, down_hi: 12'hFFF});
    set_traffic(RX_SPARSE, 20);
    run_random(120, 10);
    drain();

    // random layouts
    for (int p = 0; p < 3; p++) begin
      program_regs(rand_regs());
      set_traffic($urandom_range(RX_ALWAYS, RX_PATTERN), $urandom_range(0, 12));
      run_random(140, $urandom_range(20, 80));
      drain();
    end

    // back to the reset layout
    program_regs(dflt);
    set_traffic(RX_COIN, 3);
    run_random(120, 50);
    drain();

    if (fail_count == 0 && results_pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
